[rtl/core/dsr_pkg.sv]
// Shared types and constants for the single-wire humidity sensor reader.
// Holds the payload structs, the configuration struct and register indexes.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dsr_pkg;

  // Bits in one sensor frame: four data bytes and a checksum byte.
  localparam int FRAME_BITS = 40;

  localparam int WAKE_W    = 20;
  localparam int START_W   = 16;
  localparam int RELEASE_W = 8;
  localparam int PULSE_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_HIGH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TIMEOUT = 3'd4;

  // Register values after reset.
  localparam logic [WAKE_W-1:0]    WAKE_RST      = 20'd800000;
  localparam logic [START_W-1:0]   START_RST     = 16'd18000;
  localparam logic [RELEASE_W-1:0] RELEASE_RST   = 8'd30;
  localparam logic [PULSE_W-1:0]   THRESHOLD_RST = 7'd28;
  localparam logic [PULSE_W-1:0]   TIMEOUT_RST   = 7'd70;

  // The pulse counter saturates here.
  localparam logic [PULSE_W-1:0] PULSE_MAX = 7'd127;
  // Number of reply level phases skipped before bit timing starts.
  localparam logic [1:0] SKIP_PHASES = 2'd3;

  typedef struct packed {
    logic line_level;
    logic start_request;
  } dsr_in_t;

  typedef struct packed {
    logic       line_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       read_ok;
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temp_int;
    logic [7:0] temp_frac;
  } dsr_out_t;

  typedef struct packed {
    logic [WAKE_W-1:0]    wake_high_ticks;
    logic [START_W-1:0]   start_low_ticks;
    logic [RELEASE_W-1:0] release_ticks;
    logic [PULSE_W-1:0]   one_threshold;
    logic [PULSE_W-1:0]   pulse_timeout;
  } dsr_cfg_t;

endpackage

`default_nettype wire

[rtl/core/dsr_cfg_regs.sv]
// Configuration register file of the sensor reader.
// Depends on dsr_pkg for the register struct, indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module dsr_cfg_regs
  import dsr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_DAT_W-1:0] wr_data,
  output dsr_cfg_t                  cfg
);

  dsr_cfg_t cfg_r;
  dsr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_WAKE_HIGH:     cfg_nxt.wake_high_ticks = wr_data[WAKE_W-1:0];
        CFG_START_LOW:     cfg_nxt.start_low_ticks = wr_data[START_W-1:0];
        CFG_RELEASE:       cfg_nxt.release_ticks   = wr_data[RELEASE_W-1:0];
        CFG_ONE_THRESHOLD: cfg_nxt.one_threshold   = wr_data[PULSE_W-1:0];
        CFG_PULSE_TIMEOUT: cfg_nxt.pulse_timeout   = wr_data[PULSE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wake_high_ticks <= WAKE_RST;
      cfg_r.start_low_ticks <= START_RST;
      cfg_r.release_ticks   <= RELEASE_RST;
      cfg_r.one_threshold   <= THRESHOLD_RST;
      cfg_r.pulse_timeout   <= TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/core/dsr_step.sv]
// Read sequencer of the sensor reader: phase state, tick counters, frame shifter
// and the registered result of each tick. Depends on dsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsr_step
  import dsr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire dsr_in_t  item,
  input  wire dsr_cfg_t cfg,
  output dsr_out_t      res
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAKE     = 3'd1,
    PH_START    = 3'd2,
    PH_RELEASE  = 3'd3,
    PH_SKIP     = 3'd4,
    PH_WAITHIGH = 3'd5,
    PH_MEASURE  = 3'd6
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [WAKE_W-1:0]     phase_ticks_r, phase_ticks_nxt;
  logic [PULSE_W-1:0]    pulse_ticks_r, pulse_ticks_nxt;
  logic [1:0]            skip_count_r, skip_count_nxt;
  logic [5:0]            bit_count_r, bit_count_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  last_level_r, last_level_nxt;
  dsr_out_t              res_r, res_nxt;

  logic [WAKE_W-1:0]     ticks_inc;
  logic [PULSE_W-1:0]    pulse_inc;
  logic [1:0]            skip_inc;
  logic [5:0]            bit_inc;
  logic [FRAME_BITS-1:0] frame_shift;
  logic [7:0]            sum4;
  logic                  done;
  logic                  ok;

  assign ticks_inc   = phase_ticks_r + 20'd1;
  assign pulse_inc   = (pulse_ticks_r < PULSE_MAX) ? pulse_ticks_r + 7'd1 : pulse_ticks_r;
  assign skip_inc    = skip_count_r + 2'd1;
  assign bit_inc     = bit_count_r + 6'd1;
  assign frame_shift = {frame_r[FRAME_BITS-2:0], (pulse_ticks_r > cfg.one_threshold)};
  // Checksum is the low byte of the sum of the four data bytes.
  assign sum4 = frame_shift[39:32] + frame_shift[31:24] + frame_shift[23:16]
              + frame_shift[15:8];

  always_comb begin
    phase_nxt       = phase_r;
    phase_ticks_nxt = phase_ticks_r;
    pulse_ticks_nxt = pulse_ticks_r;
    skip_count_nxt  = skip_count_r;
    bit_count_nxt   = bit_count_r;
    frame_nxt       = frame_r;
    last_level_nxt  = last_level_r;
    done            = 1'b0;
    ok              = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        if (item.start_request) begin
          phase_nxt       = PH_WAKE;
          phase_ticks_nxt = '0;
          pulse_ticks_nxt = '0;
          skip_count_nxt  = '0;
          bit_count_nxt   = '0;
          frame_nxt       = '0;
        end
      end
      PH_WAKE: begin
        phase_ticks_nxt = ticks_inc;
        if (ticks_inc >= cfg.wake_high_ticks) begin
          phase_nxt       = PH_START;
          phase_ticks_nxt = '0;
        end
      end
      PH_START: begin
        phase_ticks_nxt = ticks_inc;
        if (ticks_inc >= {{(WAKE_W-START_W){1'b0}}, cfg.start_low_ticks}) begin
          phase_nxt       = PH_RELEASE;
          phase_ticks_nxt = '0;
        end
      end
      PH_RELEASE: begin
        phase_ticks_nxt = ticks_inc;
        if (ticks_inc >= {{(WAKE_W-RELEASE_W){1'b0}}, cfg.release_ticks}) begin
          phase_nxt       = PH_SKIP;
          phase_ticks_nxt = '0;
          last_level_nxt  = item.line_level;
          skip_count_nxt  = '0;
        end
      end
      PH_SKIP: begin
        if (item.line_level != last_level_r) begin
          last_level_nxt = item.line_level;
          skip_count_nxt = skip_inc;
          if (skip_inc >= SKIP_PHASES) begin
            skip_count_nxt = '0;
            phase_nxt      = PH_WAITHIGH;
          end
        end
      end
      PH_WAITHIGH: begin
        if (item.line_level) begin
          pulse_ticks_nxt = 7'd1;
          phase_nxt       = PH_MEASURE;
          if (7'd1 > cfg.pulse_timeout) begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_MEASURE: begin
        if (item.line_level) begin
          pulse_ticks_nxt = pulse_inc;
          if (pulse_inc > cfg.pulse_timeout) begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end else begin
          frame_nxt       = frame_shift;
          bit_count_nxt   = bit_inc;
          pulse_ticks_nxt = '0;
          if (bit_inc >= 6'(FRAME_BITS)) begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
            ok        = (frame_shift[7:0] == sum4) && (frame_shift[39:32] != 8'd0);
          end else begin
            phase_nxt = PH_WAITHIGH;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    res_nxt.line_drive_low = (phase_r == PH_START);
    res_nxt.busy_res       = (phase_nxt != PH_IDLE);
    res_nxt.done_res       = done;
    res_nxt.read_ok        = ok;
    res_nxt.humidity_int   = ok ? frame_shift[39:32] : 8'd0;
    res_nxt.humidity_frac  = ok ? frame_shift[31:24] : 8'd0;
    res_nxt.temp_int       = ok ? frame_shift[23:16] : 8'd0;
    res_nxt.temp_frac      = ok ? frame_shift[15:8]  : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      phase_ticks_r <= '0;
      pulse_ticks_r <= '0;
      skip_count_r  <= '0;
      bit_count_r   <= '0;
      frame_r       <= '0;
      last_level_r  <= 1'b1;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      pulse_ticks_r <= pulse_ticks_nxt;
      skip_count_r  <= skip_count_nxt;
      bit_count_r   <= bit_count_nxt;
      frame_r       <= frame_nxt;
      last_level_r  <= last_level_nxt;
      res_r         <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

[rtl/core/dht11_sensor_reader_unit.sv]
// A tick transferred in passes through the input register, then the sequencer's
// result register, before it appears at the output.
// Throughput: one tick per cycle unless the output stalls; the sequencer's single
// update per tick sets this. Output stalls back up through the input register
// without losing a tick. Reset (rst_n low, synchronous) empties both stages,
// returns the sequencer to idle and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module dht11_sensor_reader_unit
  import dsr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Tick channel.
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dsr_in_t              in_data,
  // Result channel, one result per tick.
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dsr_out_t                  out_data,
  // Register write channel; always ready.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic     in_valid_r, in_valid_nxt;
  dsr_in_t  in_data_r;
  logic     out_valid_r, out_valid_nxt;
  logic     advance;
  dsr_cfg_t cfg;

  // A tick moves into the sequencer when the result register is empty or its
  // contents are being transferred out in the same cycle.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register of the input stage needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  assign cfg_ready = 1'b1;

  dsr_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The sequencer advances exactly once per tick, so its state stays frozen
  // while the output side stalls.
  dsr_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .res     (out_data)
  );

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/core/dsr_checker.sv]
// Port-level checks of the sensor reader, bound to the top level.
// Depends on dsr_pkg and dht11_sensor_reader_unit.
`timescale 1ns / 1ps
`default_nettype none

module dsr_checker
  import dsr_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire dsr_out_t out_data
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A finished read leaves the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while still busy");

  // A good read is only reported on the finishing tick.
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_ok |-> out_data.done_res)
    else $error("read_ok without done");

  // Data bytes are zero unless the read was good.
  a_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_ok |->
      out_data.humidity_int == 8'd0 && out_data.humidity_frac == 8'd0 &&
      out_data.temp_int == 8'd0 && out_data.temp_frac == 8'd0)
    else $error("data bytes nonzero on a failed read");

  // The start pulse never ends a read on the same tick.
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.line_drive_low |-> out_data.busy_res)
    else $error("line driven low while idle");

endmodule

bind dht11_sensor_reader_unit dsr_checker u_dsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the single-wire humidity sensor reader.
// Emulates the sensor's reply per tick and predicts each result from its own model of the
// sequencer; depends only on dsr_pkg and dht11_sensor_reader_unit.
`timescale 1ns / 1ps

module testbench;
  import dsr_pkg::*;

  // Sequencer phases as the predictor tracks them.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_WAKE,
    SEQ_START,
    SEQ_RELEASE,
    SEQ_SKIP,
    SEQ_WAIT_HIGH,
    SEQ_MEASURE
  } seq_phase_t;

  // One row of the directed part. When load_cfg is set, the short configuration is
  // written before the row's tick. When typed is set, want is the expected result.
  typedef struct packed {
    logic     load_cfg;
    logic     typed;
    dsr_in_t  tick;
    dsr_out_t want;
  } dir_row_t;

  localparam int DIR_COUNT    = 13;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_TICKS  = 120;
  localparam int QUIET_TICKS  = 40;
  localparam int STALL_LIMIT  = 1000;

  localparam dsr_out_t IDLE_OUT  = '0;
  localparam dsr_out_t ABORT_OUT = '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00};

  // Every timed phase as short as it can be, and a zero pulse timeout so that the first
  // high tick of the first bit aborts the read.
  localparam dsr_cfg_t SHORT_CFG = '{20'd0, 16'd1, 8'd0, 7'd0, 7'd0};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  dsr_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dsr_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  dht11_sensor_reader_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the registers and of the sequencer.
  dsr_cfg_t             regs;
  seq_phase_t           seq_phase;
  logic [WAKE_W-1:0]    seq_ticks;
  logic [PULSE_W-1:0]   pulse_cnt;
  logic [1:0]           skip_cnt;
  logic [5:0]           bit_cnt;
  logic [FRAME_BITS-1:0] frame;
  logic                 prev_level;

  // Results still owed by the block, oldest first.
  dsr_out_t expected_q[$];
  int       err_count = 0;

  // Sensor emulation: the frame the emulated sensor sends in the current read, the
  // length of the high pulse it is sending now, and whether this read is pure noise.
  logic [FRAME_BITS-1:0] planned = '0;
  int                    pulse_goal = 1;
  logic                  wild = 1'b0;

  // Idle pattern of each side: a stretch of items either with no gaps or with random ones.
  int   in_left   = 0;
  int   out_left  = 0;
  logic in_calm   = 1'b0;
  logic out_calm  = 1'b0;

  // Directed rows. The first three run on the reset configuration, which must never
  // start a read.
  dir_row_t dir_rows [DIR_COUNT] = '{
    '{1'b0, 1'b1, '{1'b1, 1'b0}, IDLE_OUT},  // idle after reset, line high
    '{1'b0, 1'b1, '{1'b0, 1'b0}, IDLE_OUT},  // idle, line low
    '{1'b0, 1'b1, '{1'b1, 1'b0}, IDLE_OUT},  // idle, line high again
    '{1'b1, 1'b0, '{1'b1, 1'b1}, IDLE_OUT},  // short config, start request
    '{1'b0, 1'b0, '{1'b1, 1'b1}, IDLE_OUT},  // zero-length wake takes one tick; start ignored
    '{1'b0, 1'b0, '{1'b0, 1'b0}, IDLE_OUT},  // start pulse, line driven low
    '{1'b0, 1'b0, '{1'b1, 1'b1}, IDLE_OUT},  // release; this level is the skip reference
    '{1'b0, 1'b0, '{1'b0, 1'b0}, IDLE_OUT},  // first reply phase ends
    '{1'b0, 1'b0, '{1'b1, 1'b0}, IDLE_OUT},  // second
    '{1'b0, 1'b0, '{1'b0, 1'b0}, IDLE_OUT},  // third; now waiting for a high level
    '{1'b0, 1'b0, '{1'b0, 1'b1}, IDLE_OUT},  // still low while waiting; start ignored
    '{1'b0, 1'b1, '{1'b1, 1'b0}, ABORT_OUT}, // first high tick exceeds the zero timeout
    '{1'b0, 1'b1, '{1'b0, 1'b0}, IDLE_OUT}   // idle again after the abort
  };

  // Counts up the current timed phase and tells whether it has run its length.
  function automatic logic phase_elapsed(input logic [WAKE_W-1:0] limit);
    seq_ticks = seq_ticks + 1'b1;
    if (seq_ticks >= limit) begin
      seq_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the sequencer by one tick and returns the result that tick produces.
  function automatic dsr_out_t sequence_tick(input dsr_in_t t);
    dsr_out_t   r;
    logic       finished;
    logic       good;
    logic [7:0] sum8;
    r        = '0;
    finished = 1'b0;
    good     = 1'b0;
    r.line_drive_low = (seq_phase == SEQ_START);
    case (seq_phase)
      SEQ_IDLE: begin
        if (t.start_request) begin
          seq_phase = SEQ_WAKE;
          seq_ticks = '0;
          pulse_cnt = '0;
          skip_cnt  = '0;
          bit_cnt   = '0;
          frame     = '0;
        end
      end
      SEQ_WAKE: begin
        if (phase_elapsed(regs.wake_high_ticks)) seq_phase = SEQ_START;
      end
      SEQ_START: begin
        if (phase_elapsed(WAKE_W'(regs.start_low_ticks))) seq_phase = SEQ_RELEASE;
      end
      SEQ_RELEASE: begin
        // The level seen on the last release tick is taken as the first reply phase.
        if (phase_elapsed(WAKE_W'(regs.release_ticks))) begin
          seq_phase  = SEQ_SKIP;
          prev_level = t.line_level;
          skip_cnt   = '0;
        end
      end
      SEQ_SKIP: begin
        if (t.line_level != prev_level) begin
          prev_level = t.line_level;
          skip_cnt   = skip_cnt + 1'b1;
          if (skip_cnt >= SKIP_PHASES) begin
            skip_cnt  = '0;
            seq_phase = SEQ_WAIT_HIGH;
          end
        end
      end
      SEQ_WAIT_HIGH: begin
        if (t.line_level) begin
          pulse_cnt = 7'd1;
          seq_phase = SEQ_MEASURE;
          if (pulse_cnt > regs.pulse_timeout) begin
            finished  = 1'b1;
            seq_phase = SEQ_IDLE;
          end
        end
      end
      SEQ_MEASURE: begin
        if (t.line_level) begin
          if (pulse_cnt < PULSE_MAX) pulse_cnt = pulse_cnt + 1'b1;
          if (pulse_cnt > regs.pulse_timeout) begin
            finished  = 1'b1;
            seq_phase = SEQ_IDLE;
          end
        end else begin
          frame     = {frame[FRAME_BITS-2:0], pulse_cnt > regs.one_threshold};
          bit_cnt   = bit_cnt + 1'b1;
          pulse_cnt = '0;
          if (bit_cnt >= 6'(FRAME_BITS)) begin
            finished  = 1'b1;
            seq_phase = SEQ_IDLE;
            sum8 = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
            good = (frame[7:0] == sum8) && (frame[39:32] != 8'h00);
          end else begin
            seq_phase = SEQ_WAIT_HIGH;
          end
        end
      end
      default: begin
        seq_phase = SEQ_IDLE;
      end
    endcase
    r.busy_res = (seq_phase != SEQ_IDLE);
    r.done_res = finished;
    r.read_ok  = good;
    if (good) begin
      r.humidity_int  = frame[39:32];
      r.humidity_frac = frame[31:24];
      r.temp_int      = frame[23:16];
      r.temp_frac     = frame[15:8];
    end
    return r;
  endfunction

  // Number of cycles one side waits before its next transfer.
  function automatic int draw_gap(inout int left, inout logic calm);
    if (left == 0) begin
      left = $urandom_range(80, 20);
      calm = ($urandom_range(3, 0) == 0);
    end
    left = left - 1;
    return calm ? 0 : $urandom_range(4, 0);
  endfunction

  // Offers one tick, waits for its transfer, then records what the block owes for it.
  task automatic send_tick(input dsr_in_t t, input logic typed, input dsr_out_t want);
    int       gap;
    dsr_out_t predicted;
    gap = draw_gap(in_left, in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = sequence_tick(t);
    expected_q.push_back(typed ? want : predicted);
  endtask

  // Stops offering ticks until every owed result has been transferred.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Writes all five registers back to back and mirrors each write in the predictor.
  task automatic write_regs(input dsr_cfg_t c);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CFG_DAT_W-1:0] val [5];
    int                   i;
    idx = '{CFG_WAKE_HIGH, CFG_START_LOW, CFG_RELEASE, CFG_ONE_THRESHOLD,
            CFG_PULSE_TIMEOUT};
    val = '{c.wake_high_ticks, CFG_DAT_W'(c.start_low_ticks), CFG_DAT_W'(c.release_ticks),
            CFG_DAT_W'(c.one_threshold), CFG_DAT_W'(c.pulse_timeout)};
    for (i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        CFG_WAKE_HIGH:     regs.wake_high_ticks = val[i][WAKE_W-1:0];
        CFG_START_LOW:     regs.start_low_ticks = val[i][START_W-1:0];
        CFG_RELEASE:       regs.release_ticks   = val[i][RELEASE_W-1:0];
        CFG_ONE_THRESHOLD: regs.one_threshold   = val[i][PULSE_W-1:0];
        CFG_PULSE_TIMEOUT: regs.pulse_timeout   = val[i][PULSE_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random back-pressure, and every transfer is checked against the oldest
  // expectation, field by field.
  initial begin : result_sink
    int       gap;
    dsr_out_t want;
    forever begin
      gap = draw_gap(out_left, out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_q.size() == 0) begin
        $error("result transfer with no tick outstanding: %h", out_data);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.line_drive_low != want.line_drive_low) begin
          $error("line_drive_low: expected %0d, got %0d", want.line_drive_low,
                 out_data.line_drive_low);
          err_count++;
        end
        if (out_data.busy_res != want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
          err_count++;
        end
        if (out_data.done_res != want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_data.done_res);
          err_count++;
        end
        if (out_data.read_ok != want.read_ok) begin
          $error("read_ok: expected %0d, got %0d", want.read_ok, out_data.read_ok);
          err_count++;
        end
        if (out_data.humidity_int != want.humidity_int) begin
          $error("humidity_int: expected %0d, got %0d", want.humidity_int,
                 out_data.humidity_int);
          err_count++;
        end
        if (out_data.humidity_frac != want.humidity_frac) begin
          $error("humidity_frac: expected %0d, got %0d", want.humidity_frac,
                 out_data.humidity_frac);
          err_count++;
        end
        if (out_data.temp_int != want.temp_int) begin
          $error("temp_int: expected %0d, got %0d", want.temp_int, out_data.temp_int);
          err_count++;
        end
        if (out_data.temp_frac != want.temp_frac) begin
          $error("temp_frac: expected %0d, got %0d", want.temp_frac, out_data.temp_frac);
          err_count++;
        end
      end
    end
  end

  // Watchdog: a correct run keeps some channel transferring, so a long silence on
  // every channel means the block has hung.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Tick side: directed rows first, then phases of random reads, each phase under its
  // own register settings. Registers are only rewritten once the block has returned
  // every result and the sequencer is idle.
  initial begin : tick_source
    int         p;
    int         n;
    int         r;
    int         len;
    int         thr;
    int         tmo;
    int         lo;
    int         hi;
    logic       quiet;
    logic       allow_start;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] chk;
    dsr_cfg_t   c;
    dsr_in_t    t;

    regs       = '{WAKE_RST, START_RST, RELEASE_RST, THRESHOLD_RST, TIMEOUT_RST};
    seq_phase  = SEQ_IDLE;
    seq_ticks  = '0;
    pulse_cnt  = '0;
    skip_cnt   = '0;
    bit_cnt    = '0;
    frame      = '0;
    prev_level = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < DIR_COUNT; r++) begin
      if (dir_rows[r].load_cfg) begin
        drain();
        write_regs(SHORT_CFG);
      end
      send_tick(dir_rows[r].tick, dir_rows[r].typed, dir_rows[r].want);
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      // The first phase loads every register at its maximum and never starts a read:
      // a read at those settings would take over a million ticks.
      case (p)
        0: c = '{20'hFFFFF, 16'hFFFF, 8'hFF, 7'h7F, 7'h7F};
        1: c = '{20'd0, 16'd1, 8'd0, 7'd3, 7'd10};
        2: c = '{20'd5, 16'd3, 8'hFF, 7'd2, 7'h7F};    // longest release; no timeout
        3: c = '{20'd1, 16'd2, 8'd7, 7'd0, 7'h7F};     // every pulse decodes as a one
        4: c = '{20'd0, 16'd1, 8'd0, 7'h7F, 7'h7F};    // every pulse decodes as a zero
        5: c = '{20'd2, 16'd1, 8'd3, 7'd4, 7'd5};      // timeout just above the threshold
        default: begin
          thr = $urandom_range(6, 0);
          c.wake_high_ticks = WAKE_W'($urandom_range(30, 0));
          c.start_low_ticks = START_W'($urandom_range(30, 1));
          c.release_ticks   = RELEASE_W'($urandom_range(30, 0));
          c.one_threshold   = PULSE_W'(thr);
          if ($urandom_range(3, 0) == 0) begin
            c.pulse_timeout = PULSE_W'($urandom_range(127, 0));
          end else begin
            c.pulse_timeout = PULSE_W'(thr + $urandom_range(8, 1));
          end
        end
      endcase
      drain();
      write_regs(c);
      quiet = (p == 0);
      len   = quiet ? QUIET_TICKS : PHASE_TICKS;

      // After the phase's quota the source keeps answering, without new start
      // requests, until the read in progress has finished.
      n = 0;
      while (n < len || seq_phase != SEQ_IDLE) begin
        allow_start     = (n < len) && !quiet;
        t.line_level    = 1'($urandom_range(1, 0));
        t.start_request = (seq_phase == SEQ_IDLE) ?
                          (allow_start && ($urandom_range(5, 0) == 0)) :
                          ($urandom_range(3, 0) == 0);
        if (seq_phase == SEQ_IDLE && t.start_request) begin
          // Plan the sensor's frame for the read this tick starts: mostly a good
          // checksum and a nonzero humidity byte, sometimes neither.
          wild = ($urandom_range(7, 0) == 0);
          b0   = 8'($urandom_range(255, 1));
          if ($urandom_range(7, 0) == 0) b0 = 8'h00;
          b1  = 8'($urandom);
          b2  = 8'($urandom);
          b3  = 8'($urandom);
          chk = b0 + b1 + b2 + b3;
          if ($urandom_range(5, 0) == 0) chk = chk ^ 8'($urandom_range(255, 1));
          planned = {b0, b1, b2, b3, chk};
        end else if (seq_phase != SEQ_IDLE && !wild) begin
          // A well-behaved sensor: the line follows the phase, with a little noise
          // where the block does not listen.
          case (seq_phase)
            SEQ_WAKE, SEQ_RELEASE: t.line_level = ($urandom_range(7, 0) != 0);
            SEQ_START:             t.line_level = ($urandom_range(7, 0) == 0);
            SEQ_SKIP:              t.line_level = prev_level ^ 1'($urandom_range(1, 0));
            SEQ_WAIT_HIGH: begin
              t.line_level = ($urandom_range(3, 0) != 0);
              if (t.line_level) begin
                // A new high pulse begins; pick its length from the planned bit.
                thr = regs.one_threshold;
                tmo = regs.pulse_timeout;
                if (planned[FRAME_BITS - 1 - bit_cnt]) begin
                  lo = thr + 1;
                  hi = (tmo < thr + 4) ? tmo : thr + 4;
                end else begin
                  lo = 1;
                  hi = (thr < 4) ? thr : 4;
                end
                if (hi < lo) hi = lo;
                if (hi > 127) hi = 127;
                if (lo > hi) lo = hi;
                pulse_goal = $urandom_range(hi, lo);
                // Now and then the sensor holds the line past the timeout.
                if ($urandom_range(63, 0) == 0 && tmo < 127) pulse_goal = tmo + 1;
              end
            end
            SEQ_MEASURE:           t.line_level = (pulse_cnt < pulse_goal);
            default: ;
          endcase
        end
        send_tick(t, 1'b0, '0);
        n++;
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dsr_pkg.sv
rtl/core/dsr_cfg_regs.sv
rtl/core/dsr_step.sv
rtl/core/dht11_sensor_reader_unit.sv
rtl/core/dsr_checker.sv
tb/testbench.sv
